### rtl/bgim_pkg.sv
// bgim_pkg: shared types and constants for the battery gauge and idle manager
// command/status structs between controller and datapath, item kinds, register map
// no dependencies
package bgim_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 2'd2;

  localparam int TIMEOUT_W   = 24;
  localparam int PERCENT_W   = 7;
  localparam int BACKLIGHT_W = 8;
  localparam int QUIET_W     = 25;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_CHARGE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AWAKE_BL     = 2'd2;

  localparam logic [TIMEOUT_W-1:0]   IDLE_TIMEOUT_RST = 24'd30000;
  localparam logic [PERCENT_W-1:0]   LOW_CHARGE_RST   = 7'd20;
  localparam logic [BACKLIGHT_W-1:0] AWAKE_BL_RST     = 8'd30;

  // filter divisor and percentage scaling (990 = 1024 - 32 - 2)
  localparam int FILT_DIVISOR = 10;
  localparam int PCT_SCALED_W = 10;
  localparam logic [PCT_SCALED_W-1:0] PCT_OFFSET = 10'd320;
  localparam logic [PCT_SCALED_W-1:0] PCT_SPAN   = 10'd100;

  typedef struct packed {
    logic capture;
    logic load;
    logic div_init;
    logic div_step;
    logic div_commit;
    logic pct;
    logic finish;
  } bgim_cmd_t;

  typedef struct packed {
    logic needs_filter;
    logic have_sample;
    logic div_last;
  } bgim_stat_t;

endpackage

### rtl/bgim_in_if.sv
// bgim_in_if: input item channel, valid/ready with kind and adc reading
// depends on bgim_pkg
interface bgim_in_if #(
  parameter int ADC_BITS = bgim_pkg::ADC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [bgim_pkg::KIND_W-1:0] kind;
  logic [ADC_BITS-1:0]         adc_value;

  modport source (output valid, output kind, output adc_value, input ready);
  modport sink   (input valid, input kind, input adc_value, output ready);
endinterface

### rtl/bgim_out_if.sv
// bgim_out_if: result channel, valid/ready with gauge and idle status
// depends on bgim_pkg
interface bgim_out_if #(
  parameter int ADC_BITS = bgim_pkg::ADC_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             idle_mode;
  logic [bgim_pkg::BACKLIGHT_W-1:0] backlight_level;
  logic [bgim_pkg::PERCENT_W-1:0]   charge_percent;
  logic [ADC_BITS-1:0]              filtered_counts;
  logic                             battery_missing;
  logic                             deep_sleep_request;

  modport source (output valid, output idle_mode, output backlight_level,
                  output charge_percent, output filtered_counts,
                  output battery_missing, output deep_sleep_request, input ready);
  modport sink   (input valid, input idle_mode, input backlight_level,
                  input charge_percent, input filtered_counts,
                  input battery_missing, input deep_sleep_request, output ready);
endinterface

### rtl/bgim_ctrl.sv
// bgim_ctrl: sequencer for one request at a time and the result valid flag
// depends on bgim_pkg (command and status structs)
module bgim_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bgim_pkg::bgim_stat_t stat,
  output bgim_pkg::bgim_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_COMMIT,
    S_PCT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.load       = (state_r == S_DECIDE) && stat.needs_filter && !stat.have_sample;
    cmd.div_init   = (state_r == S_DECIDE) && stat.needs_filter && stat.have_sample;
    cmd.div_step   = (state_r == S_DIV);
    cmd.div_commit = (state_r == S_COMMIT);
    cmd.pct        = (state_r == S_PCT);
    // result register is free or drains this cycle
    cmd.finish     = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.needs_filter)    state_nxt = S_FIN;
        else if (stat.have_sample) state_nxt = S_DIV;
        else                       state_nxt = S_PCT;
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: state_nxt = S_PCT;
      S_PCT:    state_nxt = S_FIN;
      S_FIN: begin
        if (cmd.finish) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
    if (cmd.finish)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DECIDE)
    else $error("accepted request did not move to decide");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> out_valid_r)
    else $error("finished request with free result register not presented");

  a_div_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_last) |=> state_r == S_COMMIT)
    else $error("divider end not followed by commit");

endmodule

### rtl/bgim_dp.sv
// bgim_dp: filter, divide by ten by reciprocal series, percentage, idle timer and result registers
// depends on bgim_pkg; driven by bgim_ctrl commands
module bgim_dp #(
  parameter int ADC_BITS  = bgim_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = bgim_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bgim_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bgim_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [bgim_pkg::KIND_W-1:0]        in_kind,
  input  logic [ADC_BITS-1:0]                in_adc_value,
  input  bgim_pkg::bgim_cmd_t                cmd,
  output bgim_pkg::bgim_stat_t               stat,
  output logic                               out_idle_mode,
  output logic [bgim_pkg::BACKLIGHT_W-1:0]   out_backlight_level,
  output logic [bgim_pkg::PERCENT_W-1:0]     out_charge_percent,
  output logic [ADC_BITS-1:0]                out_filtered_counts,
  output logic                               out_battery_missing,
  output logic                               out_deep_sleep_request
);

  localparam int FW = ADC_BITS + FRAC_BITS;
  localparam int NW = FW + 4;              // holds 10 * 2^FW
  localparam int DIV_STEPS = 5;            // first estimate and four refinements
  localparam int CW = $clog2(DIV_STEPS);
  localparam int PW = FW + 10;
  localparam logic [NW-1:0] DIVISOR = NW'(bgim_pkg::FILT_DIVISOR);
  localparam logic [bgim_pkg::QUIET_W-1:0] QUIET_MAX = '1;

  // configuration
  logic [bgim_pkg::TIMEOUT_W-1:0]   timeout_r;
  logic [bgim_pkg::PERCENT_W-1:0]   low_charge_r;
  logic [bgim_pkg::BACKLIGHT_W-1:0] awake_bl_r;

  // state
  logic [FW-1:0]                    filter_r;
  logic                             have_sample_r;
  logic [bgim_pkg::PERCENT_W-1:0]   charge_r, charge_nxt;
  logic                             idle_r, idle_nxt;
  logic [bgim_pkg::QUIET_W-1:0]     quiet_r, quiet_nxt, quiet_inc;
  logic [bgim_pkg::BACKLIGHT_W-1:0] backlight_r, backlight_nxt;

  // latched request and divider
  logic [bgim_pkg::KIND_W-1:0] kind_r;
  logic [ADC_BITS-1:0]         adc_r;
  logic [NW-1:0]               num_r, num_init;
  logic [NW-1:0]               quot_r, quot_est, quot_x10, quot_rem, quot_fix;
  logic [CW-1:0]               cnt_r;

  // percentage
  logic [PW-1:0]                    prod;
  logic [bgim_pkg::PCT_SCALED_W-1:0] scaled, above;

  logic tick, missing, sleep_req;

  assign stat.needs_filter = (kind_r == bgim_pkg::KIND_SAMPLE) && (adc_r != '0);
  assign stat.have_sample  = have_sample_r;
  assign stat.div_last     = (cnt_r == CW'(DIV_STEPS - 1));

  // 9*old + new, then quot_r converges to 0.8 * num by shift and add
  assign num_init = (NW'(filter_r) << 3) + NW'(filter_r) + (NW'(adc_r) << FRAC_BITS);
  // estimate is never high and at most one below the true quotient
  assign quot_est = quot_r >> 3;
  assign quot_x10 = (quot_est << 3) + (quot_est << 1);
  assign quot_rem = num_r - quot_x10;
  assign quot_fix = quot_est + NW'(quot_rem >= DIVISOR);

  // filter * 990 by shift and subtract
  assign prod   = (PW'(filter_r) << 10) - (PW'(filter_r) << 5) - (PW'(filter_r) << 1);
  assign scaled = prod[PW-1:FW];
  assign above  = scaled - bgim_pkg::PCT_OFFSET;

  always_comb begin
    if (scaled <= bgim_pkg::PCT_OFFSET)    charge_nxt = '0;
    else if (above > bgim_pkg::PCT_SPAN)   charge_nxt = bgim_pkg::PERCENT_W'(bgim_pkg::PCT_SPAN);
    else                                   charge_nxt = above[bgim_pkg::PERCENT_W-1:0];
  end

  assign tick      = (kind_r == bgim_pkg::KIND_TICK) || (kind_r == bgim_pkg::KIND_SAMPLE);
  assign missing   = (kind_r == bgim_pkg::KIND_SAMPLE) && (adc_r == '0);
  assign sleep_req = tick && (charge_r != '0) && (charge_r <= low_charge_r);
  assign quiet_inc = (quiet_r == QUIET_MAX) ? quiet_r : quiet_r + bgim_pkg::QUIET_W'(1);

  always_comb begin
    quiet_nxt     = quiet_r;
    idle_nxt      = idle_r;
    backlight_nxt = backlight_r;
    if (tick) begin
      quiet_nxt = quiet_inc;
      if (quiet_inc > {1'b0, timeout_r}) begin
        idle_nxt      = 1'b1;
        backlight_nxt = '0;
      end
    end else if (kind_r == bgim_pkg::KIND_ACTIVITY) begin
      quiet_nxt = '0;
      if (idle_r) begin
        idle_nxt      = 1'b0;
        backlight_nxt = awake_bl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= bgim_pkg::IDLE_TIMEOUT_RST;
      low_charge_r  <= bgim_pkg::LOW_CHARGE_RST;
      awake_bl_r    <= bgim_pkg::AWAKE_BL_RST;
      filter_r      <= '0;
      have_sample_r <= 1'b0;
      charge_r      <= '0;
      idle_r        <= 1'b0;
      quiet_r       <= '0;
      backlight_r   <= bgim_pkg::AWAKE_BL_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bgim_pkg::REG_IDLE_TIMEOUT: timeout_r    <= cfg_wdata[bgim_pkg::TIMEOUT_W-1:0];
          bgim_pkg::REG_LOW_CHARGE:   low_charge_r <= cfg_wdata[bgim_pkg::PERCENT_W-1:0];
          bgim_pkg::REG_AWAKE_BL:     awake_bl_r   <= cfg_wdata[bgim_pkg::BACKLIGHT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        filter_r      <= FW'(adc_r) << FRAC_BITS;
        have_sample_r <= 1'b1;
      end else if (cmd.div_commit) begin
        filter_r <= quot_fix[FW-1:0];
      end
      if (cmd.pct) charge_r <= charge_nxt;
      if (cmd.finish) begin
        idle_r      <= idle_nxt;
        quiet_r     <= quiet_nxt;
        backlight_r <= backlight_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      adc_r  <= in_adc_value;
    end
    if (cmd.div_init) begin
      num_r <= num_init;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      case (cnt_r)
        CW'(0):  quot_r <= (num_r >> 1) + (num_r >> 2);
        CW'(1):  quot_r <= quot_r + (quot_r >> 4);
        CW'(2):  quot_r <= quot_r + (quot_r >> 8);
        CW'(3):  quot_r <= quot_r + (quot_r >> 16);
        default: quot_r <= quot_r + (quot_r >> 32);
      endcase
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.finish) begin
      out_idle_mode          <= idle_nxt;
      out_backlight_level    <= backlight_nxt;
      out_charge_percent     <= charge_r;
      out_filtered_counts    <= filter_r[FW-1:FRAC_BITS];
      out_battery_missing    <= missing;
      out_deep_sleep_request <= sleep_req;
    end
  end

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r |-> backlight_r == '0)
    else $error("backlight on while idle");

  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    charge_r <= bgim_pkg::PERCENT_W'(bgim_pkg::PCT_SPAN))
    else $error("charge above full scale");

  a_empty_filter: assert property (@(posedge clk) disable iff (!rst_n)
    !have_sample_r |-> filter_r == '0)
    else $error("filter loaded without a sample");

endmodule

### rtl/battery_gauge_idle_manager_top.sv
// battery_gauge_idle_manager_top: top level, joins controller and datapath
// depends on bgim_pkg, bgim_in_if, bgim_out_if, bgim_ctrl, bgim_dp
//
// One request at a time, one result per request. A tick, an activity event or
// a zero sample goes from decide straight to finish; a first nonzero sample
// also passes the percentage step; a filtered sample also passes the
// divide-by-ten of the average, which forms a reciprocal estimate over five
// shift-and-add steps and then corrects it in a commit step. The result
// register lets the next request be accepted while a result waits. Configuration
// writes take effect at once; write only while no request is in flight.
module battery_gauge_idle_manager_top #(
  parameter int ADC_BITS  = bgim_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = bgim_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bgim_in_if.sink                          in_ch,
  bgim_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bgim_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgim_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bgim_pkg::bgim_cmd_t  cmd;
  bgim_pkg::bgim_stat_t stat;

  bgim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bgim_dp #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_kind                (in_ch.kind),
    .in_adc_value           (in_ch.adc_value),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_idle_mode          (out_ch.idle_mode),
    .out_backlight_level    (out_ch.backlight_level),
    .out_charge_percent     (out_ch.charge_percent),
    .out_filtered_counts    (out_ch.filtered_counts),
    .out_battery_missing    (out_ch.battery_missing),
    .out_deep_sleep_request (out_ch.deep_sleep_request)
  );

endmodule

### test/battery_gauge_idle_manager_top_tb.sv
`timescale 1ns / 1ps
// battery_gauge_idle_manager_top_tb: self-checking bench for the battery gauge and idle manager
// directed table then random phases, each result checked against an in-bench status predictor
// depends on bgim_pkg, bgim_in_if, bgim_out_if and the rtl under battery_gauge_idle_manager_top
module battery_gauge_idle_manager_top_tb;

  localparam int ADC_BITS  = bgim_pkg::ADC_BITS_DEF;
  localparam int FRAC_BITS = bgim_pkg::FRAC_BITS_DEF;
  localparam int FILT_W    = ADC_BITS + FRAC_BITS;
  localparam logic [bgim_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] PCT_GAIN = 64'd990;
  localparam int N_ROWS   = 30;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic                             idle_mode;
    logic [bgim_pkg::BACKLIGHT_W-1:0] backlight_level;
    logic [bgim_pkg::PERCENT_W-1:0]   charge_percent;
    logic [ADC_BITS-1:0]              filtered_counts;
    logic                             battery_missing;
    logic                             deep_sleep_request;
  } status_t;

  typedef enum logic {ROW_REQ, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t         op;
    logic [1:0]      code;   // kind for a request, register index for a write
    logic [23:0]     value;  // adc reading or register data
    logic            typed;
    status_t         want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bgim_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bgim_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  bgim_in_if  in_bus ();
  bgim_out_if out_bus ();

  battery_gauge_idle_manager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the block
  logic [bgim_pkg::TIMEOUT_W-1:0]   timeout_setting = bgim_pkg::IDLE_TIMEOUT_RST;
  logic [bgim_pkg::PERCENT_W-1:0]   low_setting     = bgim_pkg::LOW_CHARGE_RST;
  logic [bgim_pkg::BACKLIGHT_W-1:0] awake_setting   = bgim_pkg::AWAKE_BL_RST;
  logic [FILT_W-1:0]                gauge_filter    = '0;
  logic                             gauge_have_sample = 1'b0;
  logic [bgim_pkg::PERCENT_W-1:0]   gauge_charge    = '0;
  logic                             gauge_idle      = 1'b0;
  logic [bgim_pkg::QUIET_W-1:0]     gauge_quiet     = '0;
  logic [bgim_pkg::BACKLIGHT_W-1:0] gauge_backlight = bgim_pkg::AWAKE_BL_RST;

  status_t expected_status[$];
  int      mismatch_count = 0;
  logic    steady = 1'b0;
  int      hold_left = 0;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{ROW_REQ, bgim_pkg::KIND_TICK, 24'd0, 1'b1,
      '{1'b0, 8'd30, 7'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_REQ, KIND_UNUSED, 24'd4095, 1'b1,
      '{1'b0, 8'd30, 7'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_REQ, bgim_pkg::KIND_SAMPLE, 24'd0, 1'b1,
      '{1'b0, 8'd30, 7'd0, 12'd0, 1'b1, 1'b0}},
    '{ROW_REQ, bgim_pkg::KIND_ACTIVITY, 24'd4095, 1'b1,
      '{1'b0, 8'd30, 7'd0, 12'd0, 1'b0, 1'b0}},
    '{ROW_REQ, bgim_pkg::KIND_SAMPLE, 24'd4095, 1'b1,
      '{1'b0, 8'd30, 7'd100, 12'd4095, 1'b0, 1'b0}},
    '{ROW_REQ, bgim_pkg::KIND_SAMPLE, 24'd4095, 1'b1,
      '{1'b0, 8'd30, 7'd100, 12'd4095, 1'b0, 1'b0}},
    '{ROW_REQ,   bgim_pkg::KIND_SAMPLE,      24'd1,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_SAMPLE,      24'd1365,     1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_LOW_CHARGE,   24'd127,      1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd2730,     1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_SAMPLE,      24'd2048,     1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_IDLE_TIMEOUT, 24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0},
    '{ROW_REQ,   KIND_UNUSED,                24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_ACTIVITY,    24'd0,        1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_AWAKE_BL,     24'd255,      1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_SAMPLE,      24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_ACTIVITY,    24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_ACTIVITY,    24'd0,        1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_IDLE_TIMEOUT, 24'd2,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_LOW_CHARGE,   24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_SAMPLE,      24'd1340,     1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_IDLE_TIMEOUT, 24'd16777215, 1'b0, '0},
    '{ROW_WRITE, bgim_pkg::REG_AWAKE_BL,     24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_ACTIVITY,    24'd0,        1'b0, '0},
    '{ROW_REQ,   bgim_pkg::KIND_TICK,        24'd0,        1'b0, '0}
  };

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic status_t predict_status(input logic [bgim_pkg::KIND_W-1:0] kind,
                                             input logic [ADC_BITS-1:0] adc);
    status_t res;
    logic [63:0] wide;
    logic [63:0] scaled;
    res = '0;
    if (kind == bgim_pkg::KIND_SAMPLE) begin
      if (adc == '0) begin
        res.battery_missing = 1'b1;
      end else begin
        wide = 64'(adc) << FRAC_BITS;
        if (!gauge_have_sample) begin
          gauge_have_sample = 1'b1;
        end else begin
          wide = (64'(gauge_filter) * 64'd9 + wide) / 64'd10;
        end
        gauge_filter = wide[FILT_W-1:0];
        scaled = (64'(gauge_filter) * PCT_GAIN) >> FILT_W;
        if (scaled <= 64'(bgim_pkg::PCT_OFFSET)) begin
          gauge_charge = '0;
        end else if (scaled - 64'(bgim_pkg::PCT_OFFSET) > 64'(bgim_pkg::PCT_SPAN)) begin
          gauge_charge = bgim_pkg::PERCENT_W'(bgim_pkg::PCT_SPAN);
        end else begin
          gauge_charge = bgim_pkg::PERCENT_W'(scaled - 64'(bgim_pkg::PCT_OFFSET));
        end
      end
    end
    if (kind == bgim_pkg::KIND_TICK || kind == bgim_pkg::KIND_SAMPLE) begin
      // count first, then compare; the count saturates
      if (gauge_quiet != '1) gauge_quiet = gauge_quiet + bgim_pkg::QUIET_W'(1);
      if (gauge_quiet > bgim_pkg::QUIET_W'(timeout_setting)) begin
        gauge_idle = 1'b1;
        gauge_backlight = '0;
      end
      if (gauge_charge != '0 && gauge_charge <= low_setting) res.deep_sleep_request = 1'b1;
    end else if (kind == bgim_pkg::KIND_ACTIVITY) begin
      if (gauge_idle) begin
        gauge_idle = 1'b0;
        gauge_backlight = awake_setting;
      end
      gauge_quiet = '0;
    end
    res.idle_mode       = gauge_idle;
    res.backlight_level = gauge_backlight;
    res.charge_percent  = gauge_charge;
    res.filtered_counts = gauge_filter[FILT_W-1:FRAC_BITS];
    return res;
  endfunction

  task automatic send_request(input logic [bgim_pkg::KIND_W-1:0] kind,
                              input logic [ADC_BITS-1:0] adc,
                              input logic typed, input status_t typed_want);
    int gap;
    status_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.adc_value <= adc;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = predict_status(kind, adc);
    expected_status.push_back(typed ? typed_want : predicted);
  endtask

  // every request gives a result, so an empty queue means the block is idle
  task automatic drain_requests();
    in_bus.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bgim_pkg::CFG_INDEX_W-1:0] index,
                           input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    case (index)
      bgim_pkg::REG_IDLE_TIMEOUT: timeout_setting = data[bgim_pkg::TIMEOUT_W-1:0];
      bgim_pkg::REG_LOW_CHARGE:   low_setting     = data[bgim_pkg::PERCENT_W-1:0];
      bgim_pkg::REG_AWAKE_BL:     awake_setting   = data[bgim_pkg::BACKLIGHT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: check on handshake, then pick the next stall
  always @(posedge clk) begin : result_check
    status_t want;
    if (out_bus.valid && out_bus.ready) begin
      if (expected_status.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        if (out_bus.idle_mode !== want.idle_mode) begin
          $error("idle_mode: expected %0d, got %0d", want.idle_mode, out_bus.idle_mode);
          mismatch_count++;
        end
        if (out_bus.backlight_level !== want.backlight_level) begin
          $error("backlight_level: expected %0d, got %0d",
                 want.backlight_level, out_bus.backlight_level);
          mismatch_count++;
        end
        if (out_bus.charge_percent !== want.charge_percent) begin
          $error("charge_percent: expected %0d, got %0d",
                 want.charge_percent, out_bus.charge_percent);
          mismatch_count++;
        end
        if (out_bus.filtered_counts !== want.filtered_counts) begin
          $error("filtered_counts: expected %0d, got %0d",
                 want.filtered_counts, out_bus.filtered_counts);
          mismatch_count++;
        end
        if (out_bus.battery_missing !== want.battery_missing) begin
          $error("battery_missing: expected %0d, got %0d",
                 want.battery_missing, out_bus.battery_missing);
          mismatch_count++;
        end
        if (out_bus.deep_sleep_request !== want.deep_sleep_request) begin
          $error("deep_sleep_request: expected %0d, got %0d",
                 want.deep_sleep_request, out_bus.deep_sleep_request);
          mismatch_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      hold_left = idle_cycles();
    end
  end

  initial begin : stimulus
    logic [bgim_pkg::KIND_W-1:0] kind;
    logic [ADC_BITS-1:0]         adc;
    logic [23:0]                 timeout_pick;
    logic [23:0]                 low_pick;
    logic [23:0]                 awake_pick;
    int                          activity_pct;
    int                          r;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = bgim_pkg::KIND_TICK;
    in_bus.adc_value = '0;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bgim_pkg::REG_IDLE_TIMEOUT;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_WRITE) begin
        drain_requests();
        write_reg(directed_rows[i].code, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i].code, directed_rows[i].value[ADC_BITS-1:0],
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_requests();
      case (p)
        0: begin
          timeout_pick = 24'd0;
          low_pick     = 24'd0;
          awake_pick   = 24'd0;
        end
        1: begin
          timeout_pick = 24'hFFFFFF;
          low_pick     = 24'd127;
          awake_pick   = 24'd255;
        end
        2: begin
          timeout_pick = 24'd1;
          low_pick     = 24'd100;
          awake_pick   = 24'($urandom_range(0, 255));
        end
        default: begin
          timeout_pick = 24'($urandom_range(0, 24));
          low_pick     = 24'($urandom_range(0, 100));
          awake_pick   = 24'($urandom_range(0, 255));
        end
      endcase
      write_reg(bgim_pkg::REG_IDLE_TIMEOUT, timeout_pick);
      write_reg(bgim_pkg::REG_LOW_CHARGE, low_pick);
      write_reg(bgim_pkg::REG_AWAKE_BL, awake_pick);
      steady = (p == 3);
      activity_pct = (p == 1) ? 3 : 15;

      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < activity_pct) kind = bgim_pkg::KIND_ACTIVITY;
        else if (r < activity_pct + 5) kind = KIND_UNUSED;
        else if (r < activity_pct + 45) kind = bgim_pkg::KIND_TICK;
        else kind = bgim_pkg::KIND_SAMPLE;
        adc = ADC_BITS'($urandom_range(0, 4095));
        if (kind == bgim_pkg::KIND_SAMPLE) begin
          // most readings sit where the charge curve is not clamped
          r = $urandom_range(0, 9);
          if (r == 0) adc = '0;
          else if (r == 1) adc = ADC_BITS'($urandom_range(1, 4095));
          else if (r == 2) adc = $urandom_range(0, 1) ? '1 : ADC_BITS'(1);
          else adc = ADC_BITS'($urandom_range(1300, 1800));
        end
        send_request(kind, adc, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_requests();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
